@@ rtl/asmlex_pkg.sv @@
// asmlex_pkg: types, codes and character constants for the assembly lexer
// no dependencies; used by assembly_lexer and both testbench modules
`timescale 1ns / 1ps

package asmlex_pkg;

   // word length limit and derived widths
   localparam int MAX_TOKEN_LEN = 256;
   localparam int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 2);
   localparam int OFFSET_BITS   = 16;
   localparam int VALUE_BITS    = 32;
   localparam int TDATA_BITS    = 64;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_COMMENT = 4'd1,
      MODE_TEXT    = 4'd2,
      MODE_SIGN    = 4'd3,
      MODE_ZERO    = 4'd4,
      MODE_HEX     = 4'd5,
      MODE_BIN     = 4'd6,
      MODE_OCT     = 4'd7,
      MODE_DEC     = 4'd8
   } mode_type;

   // token kinds
   typedef enum logic [2:0] {
      KIND_COMMA = 3'd0,
      KIND_COLON = 3'd1,
      KIND_TEXT  = 3'd2,
      KIND_NUM   = 3'd3,
      KIND_EOL   = 3'd4,
      KIND_EOF   = 3'd5,
      KIND_ERR   = 3'd6
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_HEX    = 3'd1,
      ERR_BIN    = 3'd2,
      ERR_OCT    = 3'd3,
      ERR_PREFIX = 3'd4,
      ERR_DEC    = 3'd5,
      ERR_LONG   = 3'd6
   } err_type;

   // one result word
   typedef struct packed {
      err_type                 error_code;
      logic [OFFSET_BITS-1:0]  start_offset;
      logic [8:0]              text_length;
      logic [VALUE_BITS-1:0]   value;
      kind_type                kind;
      logic                    last;
   } lex_result_type;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LC    = 8'h63;
   localparam logic [7:0] CH_LF_LO = 8'h66;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_LX    = 8'h78;

   // empty result word
   function automatic lex_result_type blank_token();
      lex_result_type t;
      t.error_code   = ERR_NONE;
      t.start_offset = '0;
      t.text_length  = '0;
      t.value        = '0;
      t.kind         = KIND_COMMA;
      t.last         = 1'b0;
      return t;
   endfunction

endpackage

@@ rtl/assembly_lexer.sv @@
// assembly_lexer: one character per word in, tokens out through a small result queue
// depends on asmlex_pkg
// a token is registered into the result queue when the word that completes it is taken
// throughput: one character per cycle while req_tready is high; a character that closes a word
//   and is itself a token gives two results, which drain at one per cycle through the four-entry queue
// req_tready is high while the result queue has room for two results
// reset clears scanner mode, offsets and the result queue; accumulator and length start at zero
`timescale 1ns / 1ps

module assembly_lexer
   import asmlex_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = ch[7:0]; tuser = at_end
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,
   // response: tdata = kind[2:0], value[34:3], text_length[43:35],
   //   start_offset[59:44], error_code[62:60], zero[63]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // scanner state
   mode_type               mode_ff, mode_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   err_type                perr_ff, perr_in;

   // result queue
   lex_result_type         queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [7:0]             c;
   logic                   is_sep;
   logic                   is_delim;
   logic                   idle_emit;
   lex_result_type         idle_tok;
   lex_result_type         word_tok;
   lex_result_type         tok0, tok1;
   logic [1:0]             n_tok;
   logic [VALUE_BITS-1:0]  neg_acc;
   logic [VALUE_BITS-1:0]  acc_x10;
   logic [3:0]             hex_val;
   logic                   is_hex;
   lex_result_type         head;

   assign c          = req_tdata;
   assign req_tready = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   // character classes
   assign is_sep   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NUL);
   assign is_delim = is_sep || (c == CH_COMMA) || (c == CH_COLON) ||
                     (c == CH_SEMI) || (c == CH_LF);

   // hex digit value
   always_comb begin
      is_hex  = 1'b1;
      hex_val = '0;
      if (c >= CH_0 && c <= CH_9) begin
         hex_val = 4'(c - CH_0);
      end else if (c >= CH_UA && c <= CH_UF) begin
         hex_val = 4'(c - CH_UA + 8'd10);
      end else if (c >= CH_LA && c <= CH_LF_LO) begin
         hex_val = 4'(c - CH_LA + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign neg_acc = VALUE_BITS'(0) - acc_ff;
   assign acc_x10 = {acc_ff[VALUE_BITS-4:0], 3'b000} + {acc_ff[VALUE_BITS-2:0], 1'b0};

   // token for a single-character delimiter seen between words
   always_comb begin
      idle_tok              = blank_token();
      idle_tok.start_offset = offset_ff;
      idle_emit             = 1'b1;
      case (c)
         CH_COMMA: idle_tok.kind = KIND_COMMA;
         CH_COLON: idle_tok.kind = KIND_COLON;
         CH_LF:    idle_tok.kind = KIND_EOL;
         default:  idle_emit = 1'b0;
      endcase
   end

   // token for the word that a delimiter closes
   always_comb begin
      word_tok              = blank_token();
      word_tok.start_offset = start_ff;
      if (len_ff > LEN_BITS'(MAX_TOKEN_LEN)) begin
         word_tok.kind       = KIND_ERR;
         word_tok.error_code = ERR_LONG;
      end else if (perr_ff != ERR_NONE) begin
         word_tok.kind       = KIND_ERR;
         word_tok.error_code = perr_ff;
      end else if (mode_ff == MODE_TEXT || mode_ff == MODE_SIGN) begin
         word_tok.kind        = KIND_TEXT;
         word_tok.text_length = 9'(len_ff);
      end else begin
         word_tok.kind  = KIND_NUM;
         word_tok.value = neg_ff ? neg_acc : acc_ff;
      end
   end

   // next scanner state and the results of one character
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      len_in    = len_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      perr_in   = perr_ff;
      tok0      = blank_token();
      tok1      = blank_token();
      n_tok     = 2'd0;

      if (req_tuser) begin
         // end of input: drop any open word or comment
         tok0.kind         = KIND_EOF;
         tok0.start_offset = offset_ff;
         n_tok             = 2'd1;
         mode_in           = MODE_IDLE;
         len_in            = '0;
         perr_in           = ERR_NONE;
      end else begin
         offset_in = offset_ff + 1'b1;
         if (mode_ff == MODE_COMMENT) begin
            if (c == CH_LF) begin
               tok0              = blank_token();
               tok0.kind         = KIND_EOL;
               tok0.start_offset = offset_ff;
               n_tok             = 2'd1;
               mode_in           = MODE_IDLE;
            end
         end else if (mode_ff == MODE_IDLE) begin
            if (idle_emit) begin
               tok0  = idle_tok;
               n_tok = 2'd1;
            end else if (c == CH_SEMI) begin
               mode_in = MODE_COMMENT;
            end else if (!is_sep) begin
               // first character of a word
               start_in = offset_ff;
               len_in   = LEN_BITS'(1);
               acc_in   = '0;
               neg_in   = 1'b0;
               perr_in  = ERR_NONE;
               if (c == CH_MINUS) begin
                  mode_in = MODE_SIGN;
                  neg_in  = 1'b1;
               end else if (c == CH_0) begin
                  mode_in = MODE_ZERO;
               end else if (c >= CH_1 && c <= CH_9) begin
                  mode_in = MODE_DEC;
                  acc_in  = VALUE_BITS'(c - CH_0);
               end else begin
                  mode_in = MODE_TEXT;
               end
            end
         end else if (is_delim) begin
            // word ends, then the delimiter acts as between words
            tok0    = word_tok;
            n_tok   = 2'd1;
            mode_in = MODE_IDLE;
            if (idle_emit) begin
               tok1  = idle_tok;
               n_tok = 2'd2;
            end else if (c == CH_SEMI) begin
               mode_in = MODE_COMMENT;
            end
         end else begin
            // character inside a word
            if (len_ff <= LEN_BITS'(MAX_TOKEN_LEN)) begin
               len_in = len_ff + 1'b1;
            end
            if (perr_ff == ERR_NONE) begin
               case (mode_ff)
                  MODE_SIGN: begin
                     if (c == CH_0) begin
                        mode_in = MODE_ZERO;
                     end else if (c >= CH_1 && c <= CH_9) begin
                        mode_in = MODE_DEC;
                        acc_in  = VALUE_BITS'(c - CH_0);
                     end else begin
                        mode_in = MODE_TEXT;
                     end
                  end
                  MODE_ZERO: begin
                     if (c == CH_LX) begin
                        mode_in = MODE_HEX;
                     end else if (c == CH_LB || c == CH_LN) begin
                        mode_in = MODE_BIN;
                     end else if (c == CH_LC) begin
                        mode_in = MODE_OCT;
                     end else begin
                        perr_in = ERR_PREFIX;
                     end
                  end
                  MODE_HEX: begin
                     if (is_hex) begin
                        acc_in = {acc_ff[VALUE_BITS-5:0], hex_val};
                     end else if (c != CH_UNDER) begin
                        perr_in = ERR_HEX;
                     end
                  end
                  MODE_BIN: begin
                     if (c == CH_0 || c == CH_1) begin
                        acc_in = {acc_ff[VALUE_BITS-2:0], c[0]};
                     end else if (c != CH_UNDER) begin
                        perr_in = ERR_BIN;
                     end
                  end
                  MODE_OCT: begin
                     if (c >= CH_0 && c <= CH_7) begin
                        acc_in = {acc_ff[VALUE_BITS-4:0], c[2:0]};
                     end else if (c != CH_UNDER) begin
                        perr_in = ERR_OCT;
                     end
                  end
                  MODE_DEC: begin
                     if (c >= CH_0 && c <= CH_9) begin
                        acc_in = acc_x10 + VALUE_BITS'(c - CH_0);
                     end else begin
                        perr_in = ERR_DEC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      // last flag on the final result of this character
      tok0.last = (n_tok == 2'd1);
      tok1.last = 1'b1;
   end

   // scanner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         len_ff    <= '0;
         start_ff  <= '0;
         offset_ff <= '0;
         perr_ff   <= ERR_NONE;
      end else if (req_fire) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         len_ff    <= len_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         perr_ff   <= perr_in;
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + QPTR_BITS'(n_tok);
         count_in  = count_ff + QCNT_BITS'(n_tok);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (req_fire && n_tok != 2'd0) begin
         queue_ff[wr_ptr_ff] <= tok0;
      end
      if (req_fire && n_tok == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= tok1;
      end
   end

   // response word
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {1'b0, head.error_code, head.start_offset, head.text_length,
                        head.value, head.kind};

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_eof_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> (mode_ff == MODE_IDLE) && (perr_ff == ERR_NONE))
      else $error("scanner not idle after end of input");

   a_eof_offset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> $stable(offset_ff))
      else $error("offset moved on end of input");

   a_char_offset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser) |=> (offset_ff == $past(offset_ff) + 1'b1))
      else $error("offset did not advance on a character");

endmodule

@@ tb/sv/lexer_token_checker.sv @@
// lexer_token_checker: watches the character and token streams of assembly_lexer,
// predicts the tokens each accepted character gives and compares them field by field
// depends on asmlex_pkg
`timescale 1ns / 1ps

module lexer_token_checker
   import asmlex_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // ch[7:0]
   input  logic                  req_tuser,   // at_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [TDATA_BITS-1:0] rsp_tdata,   // kind, value, text_length, start_offset, error_code
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    tokens_pending
);

   // mirrored scanner state
   mode_type               scan_mode  = MODE_IDLE;
   logic [VALUE_BITS-1:0]  acc        = '0;
   logic                   neg        = 1'b0;
   int unsigned            word_len   = 0;
   logic [OFFSET_BITS-1:0] word_start = '0;
   logic [OFFSET_BITS-1:0] char_pos   = '0;
   err_type                word_err   = ERR_NONE;

   lex_result_type expected_tokens[$];

   initial begin
      fail_count     = 0;
      tokens_pending = 0;
   end

   function automatic void push_token(kind_type k, logic [VALUE_BITS-1:0] v, logic [8:0] len,
                                      logic [OFFSET_BITS-1:0] st, err_type e);
      lex_result_type t;
      t.kind         = k;
      t.value        = v;
      t.text_length  = len;
      t.start_offset = st;
      t.error_code   = e;
      t.last         = 1'b0;
      expected_tokens.push_back(t);
   endfunction

   function automatic logic is_separator(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NUL || c == CH_COMMA ||
             c == CH_COLON || c == CH_SEMI || c == CH_LF;
   endfunction

   // character seen between tokens
   function automatic void idle_char(logic [7:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_NUL: begin
         end
         CH_COMMA: push_token(KIND_COMMA, '0, '0, char_pos, ERR_NONE);
         CH_COLON: push_token(KIND_COLON, '0, '0, char_pos, ERR_NONE);
         CH_LF:    push_token(KIND_EOL, '0, '0, char_pos, ERR_NONE);
         CH_SEMI:  scan_mode = MODE_COMMENT;
         default: begin
            word_start = char_pos;
            word_len   = 1;
            acc        = '0;
            neg        = 1'b0;
            word_err   = ERR_NONE;
            if (c == CH_MINUS) begin
               scan_mode = MODE_SIGN;
               neg       = 1'b1;
            end else if (c == CH_0) begin
               scan_mode = MODE_ZERO;
            end else if (c >= CH_1 && c <= CH_9) begin
               scan_mode = MODE_DEC;
               acc       = 32'(c - CH_0);
            end else begin
               scan_mode = MODE_TEXT;
            end
         end
      endcase
   endfunction

   // tokens caused by one accepted word on the character channel
   function automatic void predict_tokens(logic [7:0] c, logic at_end);
      int                    queued_prior;
      logic [VALUE_BITS-1:0] v;
      lex_result_type        t;
      queued_prior = expected_tokens.size();
      if (at_end) begin
         // end of input drops any open word or comment
         push_token(KIND_EOF, '0, '0, char_pos, ERR_NONE);
         scan_mode = MODE_IDLE;
         word_len  = 0;
         word_err  = ERR_NONE;
      end else begin
         if (scan_mode == MODE_COMMENT) begin
            if (c == CH_LF) begin
               push_token(KIND_EOL, '0, '0, char_pos, ERR_NONE);
               scan_mode = MODE_IDLE;
            end
         end else if (scan_mode == MODE_IDLE) begin
            idle_char(c);
         end else if (is_separator(c)) begin
            // close the word, then treat the separator as between tokens
            v = neg ? (32'd0 - acc) : acc;
            if (word_len > MAX_TOKEN_LEN)
               push_token(KIND_ERR, '0, '0, word_start, ERR_LONG);
            else if (word_err != ERR_NONE)
               push_token(KIND_ERR, '0, '0, word_start, word_err);
            else if (scan_mode == MODE_TEXT || scan_mode == MODE_SIGN)
               push_token(KIND_TEXT, '0, 9'(word_len), word_start, ERR_NONE);
            else
               push_token(KIND_NUM, v, '0, word_start, ERR_NONE);
            scan_mode = MODE_IDLE;
            idle_char(c);
         end else begin
            // inside a word: length saturates one past the limit
            if (word_len <= MAX_TOKEN_LEN)
               word_len++;
            if (word_err == ERR_NONE) begin
               case (scan_mode)
                  MODE_SIGN: begin
                     if (c == CH_0) begin
                        scan_mode = MODE_ZERO;
                     end else if (c >= CH_1 && c <= CH_9) begin
                        scan_mode = MODE_DEC;
                        acc       = 32'(c - CH_0);
                     end else begin
                        scan_mode = MODE_TEXT;
                     end
                  end
                  MODE_ZERO: begin
                     if (c == CH_LX)
                        scan_mode = MODE_HEX;
                     else if (c == CH_LB || c == CH_LN)
                        scan_mode = MODE_BIN;
                     else if (c == CH_LC)
                        scan_mode = MODE_OCT;
                     else
                        word_err = ERR_PREFIX;
                  end
                  MODE_HEX: begin
                     if (c >= CH_0 && c <= CH_9)
                        acc = (acc << 4) + 32'(c - CH_0);
                     else if (c >= CH_UA && c <= CH_UF)
                        acc = (acc << 4) + 32'(c - CH_UA) + 32'd10;
                     else if (c >= CH_LA && c <= CH_LF_LO)
                        acc = (acc << 4) + 32'(c - CH_LA) + 32'd10;
                     else if (c != CH_UNDER)
                        word_err = ERR_HEX;
                  end
                  MODE_BIN: begin
                     if (c == CH_0 || c == CH_1)
                        acc = (acc << 1) + 32'(c - CH_0);
                     else if (c != CH_UNDER)
                        word_err = ERR_BIN;
                  end
                  MODE_OCT: begin
                     if (c >= CH_0 && c <= CH_7)
                        acc = (acc << 3) + 32'(c - CH_0);
                     else if (c != CH_UNDER)
                        word_err = ERR_OCT;
                  end
                  MODE_DEC: begin
                     if (c >= CH_0 && c <= CH_9)
                        acc = acc * 32'd10 + 32'(c - CH_0);
                     else
                        word_err = ERR_DEC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         char_pos = char_pos + 1'b1;
      end
      // mark the final token of this word
      if (expected_tokens.size() > queued_prior) begin
         t      = expected_tokens.pop_back();
         t.last = 1'b1;
         expected_tokens.push_back(t);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   // compare tokens first, then predict from the character taken at the same edge
   always @(posedge clock) begin : watch
      lex_result_type want;
      if (reset) begin
         scan_mode  = MODE_IDLE;
         acc        = '0;
         neg        = 1'b0;
         word_len   = 0;
         word_start = '0;
         char_pos   = '0;
         word_err   = ERR_NONE;
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("token with none expected: kind %0d start_offset %0d",
                      rsp_tdata[2:0], rsp_tdata[59:44]);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("kind", want.kind, rsp_tdata[2:0]);
               check_field("value", want.value, rsp_tdata[34:3]);
               check_field("text_length", want.text_length, rsp_tdata[43:35]);
               check_field("start_offset", want.start_offset, rsp_tdata[59:44]);
               check_field("error_code", want.error_code, rsp_tdata[62:60]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            predict_tokens(req_tdata, req_tuser);
      end
      tokens_pending <= expected_tokens.size();
   end

endmodule

@@ tb/sv/assembly_lexer_tb.sv @@
// assembly_lexer_tb: drives character streams into assembly_lexer with bursty input and a stalling
// output, and gives the verdict; depends on asmlex_pkg, assembly_lexer and lexer_token_checker
`timescale 1ns / 1ps

module assembly_lexer_tb;
   import asmlex_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 400;
   // random part; the directed and length-limit words add about another thousand
   localparam int RANDOM_ITEMS = 400;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;   // ch[7:0]
   logic                  req_tuser  = 1'b0;    // at_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0] rsp_tdata;            // kind, value, text_length, start_offset, error_code
   logic                  rsp_tlast;

   int fail_count;
   int tokens_pending;
   int burst_left    = 0;
   int chars_counted = 0;
   int holds_wanted  = 0;
   int holds_done    = 0;
   int cycle_count   = 0;
   logic [7:0] char_queue[$];

   assembly_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lexer_token_checker token_watch (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one word, in bursts with idle gaps between them; returns at a falling edge
   task automatic send_char(logic [7:0] ch, logic at_end);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= at_end;
      do
         @(posedge clock);
      while (!req_tready);
      burst_left--;
      chars_counted++;
      @(negedge clock);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         char_queue.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // a random byte from 33 to 255 that can sit inside a word
   function automatic logic [7:0] rand_word_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 255));
      if (c == CH_COMMA || c == CH_COLON || c == CH_SEMI)
         c = CH_UNDER;
      return c;
   endfunction

   task automatic flush_chars();
      while (char_queue.size() > 0)
         send_char(char_queue.pop_front(), 1'b0);
   endtask

   // one random word of some class, then a separator, comment or end of input
   task automatic add_word();
      int         n;
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0: begin
            if ($urandom_range(0, 1)) push_text("-");
            push_text("0x");
            repeat ($urandom_range(1, 10)) char_queue.push_back(pick("0123456789abcdefABCDEF_"));
         end
         1: begin
            push_text("0");
            char_queue.push_back(pick("bn"));
            repeat ($urandom_range(1, 34)) char_queue.push_back(pick("01_"));
         end
         2: begin
            if ($urandom_range(0, 1)) push_text("-");
            push_text("0c");
            repeat ($urandom_range(1, 12)) char_queue.push_back(pick("01234567_"));
         end
         3, 4: begin
            if ($urandom_range(0, 2) == 0) push_text("-");
            char_queue.push_back(pick("123456789"));
            repeat ($urandom_range(0, 11)) char_queue.push_back(pick("0123456789"));
         end
         5: begin
            if ($urandom_range(0, 1)) push_text("-");
            push_text("0");
         end
         6, 7: begin
            char_queue.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_.$"));
            repeat ($urandom_range(0, 8)) char_queue.push_back(rand_word_char());
         end
         8: begin
            push_text("-");
            repeat ($urandom_range(0, 3)) char_queue.push_back(pick("abxyz_-."));
         end
         9: begin
            // number with a bad digit somewhere inside
            case ($urandom_range(0, 3))
               0: push_text("0x");
               1: push_text("0b");
               2: push_text("0c");
               default: push_text("1");
            endcase
            n = $urandom_range(0, 4);
            repeat (n) char_queue.push_back(pick("01"));
            char_queue.push_back(rand_word_char());
            repeat ($urandom_range(0, 3)) char_queue.push_back(rand_word_char());
         end
         10: begin
            push_text("0");
            char_queue.push_back(rand_word_char());
            repeat ($urandom_range(0, 2)) char_queue.push_back(rand_word_char());
         end
         default: begin
            repeat ($urandom_range(1, 4)) char_queue.push_back(8'($urandom_range(0, 255)));
         end
      endcase
      case ($urandom_range(0, 11))
         0, 1, 2: char_queue.push_back(CH_SPACE);
         3:       char_queue.push_back(CH_TAB);
         4:       char_queue.push_back(CH_NUL);
         5, 6:    char_queue.push_back(CH_COMMA);
         7:       char_queue.push_back(CH_COLON);
         8, 9:    char_queue.push_back(CH_LF);
         10: begin
            char_queue.push_back(CH_SEMI);
            repeat ($urandom_range(0, 8)) begin
               c = 8'($urandom_range(0, 255));
               char_queue.push_back(c == CH_LF ? CH_SPACE : c);
            end
            char_queue.push_back(CH_LF);
         end
         default: begin
            // end of input cuts the word off
            flush_chars();
            send_char(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
      flush_chars();
   endtask

   // stimulus
   initial begin : stimulus
      string directed;
      int    lengths[2];
      logic  mid_hold_done;
      mid_hold_done = 1'b0;
      lengths       = '{256, 257};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // label, colon, hex with underscore, comma, negative binary, bad prefix,
      // bad decimal, lone minus, tab, newline, comment, end of input
      directed = "a:0x1F_,-0b1 0q 9z -\t\n;c\n";
      for (int i = 0; i < directed.len(); i++)
         send_char(directed[i], 1'b0);
      send_char(8'hFF, 1'b1);
      send_char(CH_7, 1'b0);
      send_char(8'h00, 1'b1);

      // random words; the receiver holds off at the start and again midway
      holds_wanted++;
      chars_counted = 0;
      while (chars_counted < RANDOM_ITEMS) begin
         if (chars_counted >= RANDOM_ITEMS / 2 && !mid_hold_done) begin
            mid_hold_done = 1'b1;
            holds_wanted++;
         end
         add_word();
      end

      // words at and just past the length limit: text, and hex with a bad digit
      foreach (lengths[k]) begin
         push_text("t");
         repeat (lengths[k] - 1) char_queue.push_back(rand_word_char());
         push_text(",0x");
         repeat (lengths[k] - 2) char_queue.push_back(pick("0123456789abcdefg_"));
         char_queue.push_back(CH_LF);
         flush_chars();
      end

      req_tvalid <= 1'b0;
      wait (tokens_pending == 0);
      repeat (12) @(posedge clock);
      if (fail_count == 0 && tokens_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // token receiver: random stall stretches, plus long hold-offs on request
   initial begin : drain
      int mode;
      int span;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holds_done < holds_wanted) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ($urandom_range(0, 7) != 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // timeout
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/asmlex_pkg.sv
rtl/assembly_lexer.sv
tb/sv/lexer_token_checker.sv
tb/sv/assembly_lexer_tb.sv
